### design/pncs_pkg.sv
// Package for the redmean nearest-colour palette search.
// Holds request types, command codes and distance constants.
// No dependencies.
`default_nettype none

package pncs_pkg;

	// Command codes carried by a request
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Redmean weighting constants
	localparam int unsigned RED_BIAS    = 512;
	localparam int unsigned BLUE_BIAS   = 767;
	localparam int unsigned SCALE_SHIFT = 8;
	localparam int unsigned GREEN_SHIFT = 2;   // green weight of 4

	// Field widths
	localparam int unsigned CH_W   = 8;
	localparam int unsigned SIZE_W = 9;
	localparam int unsigned DIST_W = 20;
	localparam int unsigned SQ_W   = 2 * CH_W;
	localparam int unsigned TERM_W = 18;

	// Depth of the request queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;

	// One classified request
	typedef struct packed {
		logic            op;
		logic [CH_W-1:0] entry_index;
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pncs_req_t;

	// Queue status seen by its neighbours
	typedef struct packed {
		logic full;
		logic not_empty;
	} pncs_qstat_t;

endpackage

`default_nettype wire

### design/palette_nearest_colour_search.sv
// Redmean nearest-colour search over a palette of up to PALETTE_DEPTH entries.
// A write is stored after the front register and the queue; writes are taken one per cycle
// while in_stall is low. A query over n entries reads one entry per cycle through the memory
// read port into the s1-s3 pipeline and compare stage; an empty palette answers from idle.
// Queries do not overlap; a stalled result holds back the next query.
// Reset clears control state and sets palette_size to 256; palette contents undefined.
`default_nettype none

module palette_nearest_colour_search #(
	parameter int unsigned PALETTE_DEPTH = 256
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_write,
	input  wire  [pncs_pkg::SIZE_W-1:0]    cfg_data,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire                            command,
	input  wire  [pncs_pkg::CH_W-1:0]      entry_index,
	input  wire  [pncs_pkg::CH_W-1:0]      red,
	input  wire  [pncs_pkg::CH_W-1:0]      green,
	input  wire  [pncs_pkg::CH_W-1:0]      blue,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [pncs_pkg::CH_W-1:0]      nearest_index,
	output logic [pncs_pkg::DIST_W-1:0]    best_distance
);
	import pncs_pkg::*;

	logic [SIZE_W-1:0] palette_size_q;
	pncs_qstat_t       q_stat;
	pncs_req_t         push_req;
	pncs_req_t         head_req;
	logic              q_push;
	logic              q_pop;

	// Palette size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_size_q <= SIZE_W'(256);
		end else if (cfg_write) begin
			palette_size_q <= cfg_data;
		end
	end

	pncs_front #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.entry_index (entry_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.q_stat      (q_stat),
		.q_push      (q_push),
		.q_req       (push_req)
	);

	pncs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_req (push_req),
		.pop      (q_pop),
		.head_req (head_req),
		.stat     (q_stat)
	);

	pncs_back #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.palette_size  (palette_size_q),
		.q_stat        (q_stat),
		.head_req      (head_req),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.nearest_index (nearest_index),
		.best_distance (best_distance)
	);

`ifndef NO_ASSERTIONS
	// The front never pushes into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_stat.full)
		else $error("request pushed into full queue");

	// The engine never pops an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_stat.not_empty)
		else $error("request popped from empty queue");

	// A query is only taken while no result is waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && head_req.op == OP_QUERY) |-> !out_valid)
		else $error("query started over a pending result");
`endif

endmodule

`default_nettype wire

### design/pncs_front.sv
// Front end: takes input requests, classifies them and pushes them to the queue.
// Writes beyond the palette depth are dropped here. Depends on pncs_pkg.
`default_nettype none

module pncs_front #(
	parameter int unsigned PALETTE_DEPTH = 256
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire                          command,
	input  wire  [pncs_pkg::CH_W-1:0]    entry_index,
	input  wire  [pncs_pkg::CH_W-1:0]    red,
	input  wire  [pncs_pkg::CH_W-1:0]    green,
	input  wire  [pncs_pkg::CH_W-1:0]    blue,
	input  pncs_pkg::pncs_qstat_t        q_stat,
	output logic                         q_push,
	output pncs_pkg::pncs_req_t          q_req
);
	import pncs_pkg::*;

	logic      valid_q;
	pncs_req_t req_q;
	logic      accept;
	logic      keep;

	// Hold a request while the queue is full
	assign in_stall = valid_q && q_stat.full;
	assign accept   = in_valid && !in_stall;
	assign q_push   = valid_q && !q_stat.full;
	assign q_req    = req_q;

	// Queries always pass; writes only inside the palette
	assign keep = (command == OP_QUERY) ||
		({1'b0, entry_index} < SIZE_W'(PALETTE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= keep;
		end else if (q_push) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.op          <= command;
			req_q.entry_index <= entry_index;
			req_q.red         <= red;
			req_q.green       <= green;
			req_q.blue        <= blue;
		end
	end

endmodule

`default_nettype wire

### design/pncs_queue.sv
// Short request queue decoupling the front end from the search engine.
// Register FIFO of QUEUE_DEPTH entries. Depends on pncs_pkg.
`default_nettype none

module pncs_queue (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  pncs_pkg::pncs_req_t    push_req,
	input  wire                    pop,
	output pncs_pkg::pncs_req_t    head_req,
	output pncs_pkg::pncs_qstat_t  stat
);
	import pncs_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = PTR_W + 1;

	pncs_req_t          fifo_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign stat.full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.not_empty = (count_q != '0);
	assign head_req       = fifo_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_req;
		end
	end

endmodule

`default_nettype wire

### design/pncs_back.sv
// Back end: palette memory and the redmean search engine.
// One shared distance pipeline scores one entry per cycle. Depends on pncs_pkg.
`default_nettype none

module pncs_back #(
	parameter int unsigned PALETTE_DEPTH = 256
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire  [pncs_pkg::SIZE_W-1:0]       palette_size,
	input  pncs_pkg::pncs_qstat_t             q_stat,
	input  pncs_pkg::pncs_req_t               head_req,
	output logic                              q_pop,
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic [pncs_pkg::CH_W-1:0]         nearest_index,
	output logic [pncs_pkg::DIST_W-1:0]       best_distance
);
	import pncs_pkg::*;

	localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH);
	localparam int unsigned PROD_W = 10 + SQ_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]            state_q;
	logic [SIZE_W-1:0]     n_q;
	logic [SIZE_W-1:0]     scan_q;
	logic [SIZE_W-1:0]     n_sat;
	logic [CH_W-1:0]       qr_q, qg_q, qb_q;
	logic [3*CH_W-1:0]     palette_q [PALETTE_DEPTH];

	// Pipeline: s1 memory read, s2 squares, s3 weighted terms
	logic [3*CH_W-1:0]     rd_data_s1;
	logic                  valid_s1, first_s1, last_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [SQ_W-1:0]       dr2_s2, dg2_s2, db2_s2;
	logic [CH_W-1:0]       rm_s2;
	logic                  valid_s2, first_s2, last_s2;
	logic [IDX_W-1:0]      idx_s2;
	logic [TERM_W-1:0]     tr_s3, tg_s3, tb_s3;
	logic                  valid_s3, first_s3, last_s3;
	logic [IDX_W-1:0]      idx_s3;

	logic [DIST_W-1:0]     best_d_q;
	logic [IDX_W-1:0]      best_i_q;
	logic                  out_valid_q;
	logic [CH_W-1:0]       nearest_q;
	logic [DIST_W-1:0]     dist_q;

	logic                  start;
	logic                  is_query;
	logic [CH_W-1:0]       e_r, e_g, e_b;
	logic [CH_W-1:0]       dr, dg, db;
	logic [CH_W:0]         rsum;
	logic [9:0]            w_r, w_b;
	logic [PROD_W-1:0]     pr, pb;
	logic [DIST_W-1:0]     d_sum;
	logic                  better;
	logic [DIST_W-1:0]     new_d;
	logic [IDX_W-1:0]      new_i;

	assign out_valid     = out_valid_q;
	assign nearest_index = nearest_q;
	assign best_distance = dist_q;

	// Dequeue: writes any time idle, queries only with a free result register
	assign is_query = (head_req.op == OP_QUERY);
	assign start    = (state_q == ST_IDLE) && q_stat.not_empty;
	assign q_pop    = start && (!is_query || !out_valid_q);

	assign n_sat = (palette_size > SIZE_W'(PALETTE_DEPTH)) ?
		SIZE_W'(PALETTE_DEPTH) : palette_size;

	// Palette memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (q_pop && !is_query) begin
			palette_q[head_req.entry_index[IDX_W-1:0]] <=
				{head_req.red, head_req.green, head_req.blue};
		end
		rd_data_s1 <= palette_q[scan_q[IDX_W-1:0]];
	end

	// Stage 2 datapath: differences, red mean and squares
	assign e_r  = rd_data_s1[3*CH_W-1:2*CH_W];
	assign e_g  = rd_data_s1[2*CH_W-1:CH_W];
	assign e_b  = rd_data_s1[CH_W-1:0];
	assign dr   = (e_r > qr_q) ? (e_r - qr_q) : (qr_q - e_r);
	assign dg   = (e_g > qg_q) ? (e_g - qg_q) : (qg_q - e_g);
	assign db   = (e_b > qb_q) ? (e_b - qb_q) : (qb_q - e_b);
	assign rsum = {1'b0, e_r} + {1'b0, qr_q};

	// Stage 3 datapath: channel weights
	assign w_r = 10'(RED_BIAS) + {2'b00, rm_s2};
	assign w_b = 10'(BLUE_BIAS) - {2'b00, rm_s2};
	assign pr  = w_r * dr2_s2;
	assign pb  = w_b * db2_s2;

	// Compare stage: running first minimum
	assign d_sum  = DIST_W'(tr_s3) + DIST_W'(tg_s3) + DIST_W'(tb_s3);
	assign better = first_s3 || (d_sum < best_d_q);
	assign new_d  = better ? d_sum : best_d_q;
	assign new_i  = better ? idx_s3 : best_i_q;

	always_ff @(posedge clk) begin
		if (q_pop && is_query) begin
			qr_q <= head_req.red;
			qg_q <= head_req.green;
			qb_q <= head_req.blue;
			n_q  <= n_sat;
		end
		idx_s1   <= scan_q[IDX_W-1:0];
		first_s1 <= (scan_q == '0);
		last_s1  <= (scan_q == n_q - SIZE_W'(1));

		dr2_s2   <= dr * dr;
		dg2_s2   <= dg * dg;
		db2_s2   <= db * db;
		rm_s2    <= rsum[CH_W:1];
		idx_s2   <= idx_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;

		tr_s3    <= pr[PROD_W-1:SCALE_SHIFT];
		tg_s3    <= TERM_W'({dg2_s2, GREEN_SHIFT'(0)});
		tb_s3    <= pb[PROD_W-1:SCALE_SHIFT];
		idx_s3   <= idx_s2;
		first_s3 <= first_s2;
		last_s3  <= last_s2;

		if (valid_s3) begin
			best_d_q <= new_d;
			best_i_q <= new_i;
		end
	end

	// Sequencer, stage valids and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_q      <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
			nearest_q   <= '0;
			dist_q      <= '0;
		end else begin
			valid_s1 <= (state_q == ST_SCAN);
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;

			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					scan_q <= '0;
					if (q_pop && is_query) begin
						if (n_sat == '0) begin
							// Empty palette answers at once
							out_valid_q <= 1'b1;
							nearest_q   <= '0;
							dist_q      <= '0;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + SIZE_W'(1);
					if (scan_q == n_q - SIZE_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (valid_s3 && last_s3) begin
						out_valid_q <= 1'b1;
						nearest_q   <= CH_W'(new_i);
						dist_q      <= new_d;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
